// ----- hw/rtl/mth_pkg.sv -----
// package for the motion trail history block
// types, constants and controller command codes shared by all modules
// no dependencies
package mth_pkg;

  localparam int TRAIL_SEGMENTS = 32;
  localparam int DEPTH = TRAIL_SEGMENTS + 1;
  localparam int IDX_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_UP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LOOK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 3'd3;

  // axis select code for the half height product
  localparam logic [1:0] AX_HALF = 2'd3;

  typedef struct packed {
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   point_index;
    logic signed [31:0] top_x;
    logic signed [31:0] top_y;
    logic signed [31:0] top_z;
    logic signed [31:0] bottom_x;
    logic signed [31:0] bottom_y;
    logic signed [31:0] bottom_z;
    logic               last_point;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_ACC,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_DIV_INIT,
    OP_DIV,
    OP_CINIT,
    OP_MULN,
    OP_ADD,
    OP_SAT,
    OP_PUSH,
    OP_EMIT,
    OP_ROTATE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       ax;
    logic [1:0]       comp;
    logic             last_step;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cmd_t;

endpackage

// ----- hw/rtl/motion_trail_history.sv -----
// top level of the motion trail history block
// joins the controller and the datapath; depends on mth_pkg, mth_ctrl, mth_dp
//
//   channel   handshake            word
//   in        in_valid/in_ready    in_word   (one parent frame)
//   out       out_valid/out_ready  out_word  (one point pair, newest first)
//   cfg       cfg_we               cfg_index, cfg_data
//
// a frame runs through the shared multiplier per axis, the one-bit-a-step square root
// per axis and divider per component, the centers and one push, then emits its 33 pairs.
// synchronous reset clears control, configuration and the primed flag.
// a stalled output holds its word; no frame is taken until the oldest pair leaves.
module motion_trail_history (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mth_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mth_pkg::out_word_t             out_word,
  input  logic                           cfg_we,
  input  logic [mth_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mth_pkg::CFG_DATA_W-1:0] cfg_data
);

  mth_pkg::cmd_t cmd;

  mth_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mth_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_word  (out_word)
  );

endmodule

// ----- hw/rtl/mth_ctrl.sv -----
// controller state machine for the motion trail history block
// sequences normalization, center math, history push and emission
// depends on mth_pkg
module mth_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output mth_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ACC, S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV,
    S_CINIT, S_MUL, S_ADD, S_SAT, S_PUSH, S_EMIT, S_WAIT
  } state_t;

  state_t                    state;
  logic [1:0]                ax;
  logic [1:0]                comp;
  logic [4:0]                step;
  logic [mth_pkg::IDX_W-1:0] idx;

  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd16;
  localparam logic [mth_pkg::IDX_W-1:0] IDX_LAST = mth_pkg::IDX_W'(mth_pkg::DEPTH - 1);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_WAIT);

  always_comb begin
    cmd.ax        = ax;
    cmd.comp      = comp;
    cmd.idx       = idx;
    cmd.last      = (idx == IDX_LAST);
    cmd.last_step = (state == S_DIV) && (step == DIV_LAST);
    unique case (state)
      S_IDLE:      cmd.op = in_valid ? mth_pkg::OP_LOAD : mth_pkg::OP_NONE;
      S_SQ:        cmd.op = mth_pkg::OP_SQ;
      S_ACC:       cmd.op = mth_pkg::OP_ACC;
      S_SQRT_INIT: cmd.op = mth_pkg::OP_SQRT_INIT;
      S_SQRT:      cmd.op = mth_pkg::OP_SQRT;
      S_DIV_INIT:  cmd.op = mth_pkg::OP_DIV_INIT;
      S_DIV:       cmd.op = mth_pkg::OP_DIV;
      S_CINIT:     cmd.op = mth_pkg::OP_CINIT;
      S_MUL:       cmd.op = mth_pkg::OP_MULN;
      S_ADD:       cmd.op = mth_pkg::OP_ADD;
      S_SAT:       cmd.op = mth_pkg::OP_SAT;
      S_PUSH:      cmd.op = mth_pkg::OP_PUSH;
      S_EMIT:      cmd.op = mth_pkg::OP_EMIT;
      S_WAIT:      cmd.op = out_ready ? mth_pkg::OP_ROTATE : mth_pkg::OP_NONE;
      default:     cmd.op = mth_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax    <= '0;
      comp  <= '0;
      step  <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SQ;
            ax    <= '0;
            comp  <= '0;
          end
        end
        S_SQ: state <= S_ACC;
        S_ACC: begin
          if (comp == 2'd2) begin
            state <= S_SQRT_INIT;
            comp  <= '0;
          end else begin
            state <= S_SQ;
            comp  <= comp + 2'd1;
          end
        end
        S_SQRT_INIT: begin
          state <= S_SQRT;
          step  <= '0;
        end
        S_SQRT: begin
          if (step == SQRT_LAST) state <= S_DIV_INIT;
          step <= step + 5'd1;
        end
        S_DIV_INIT: begin
          state <= S_DIV;
          step  <= '0;
        end
        S_DIV: begin
          step <= step + 5'd1;
          if (step == DIV_LAST) begin
            if (comp == 2'd2) begin
              comp <= '0;
              if (ax == 2'd2) begin
                ax    <= '0;
                state <= S_CINIT;
              end else begin
                ax    <= ax + 2'd1;
                state <= S_SQ;
              end
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DIV_INIT;
            end
          end
        end
        S_CINIT: begin
          state <= S_MUL;
          ax    <= '0;
        end
        S_MUL: state <= (ax == mth_pkg::AX_HALF) ? S_SAT : S_ADD;
        S_ADD: begin
          ax    <= ax + 2'd1;
          state <= S_MUL;
        end
        S_SAT: begin
          if (comp == 2'd2) begin
            state <= S_PUSH;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_CINIT;
          end
        end
        S_PUSH: begin
          state <= S_EMIT;
          idx   <= '0;
        end
        S_EMIT: state <= S_WAIT;
        S_WAIT: begin
          if (out_ready) begin
            if (idx == IDX_LAST) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a word is pending");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(idx))
    else $error("pending word dropped");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && cmd.last |=> in_ready)
    else $error("not idle after oldest pair");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> idx <= IDX_LAST)
    else $error("point index past oldest entry");

endmodule

// ----- hw/rtl/mth_dp.sv -----
// datapath for the motion trail history block
// shared multiplier, bit-serial square root and divider, trail shift line
// depends on mth_pkg
module mth_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  mth_pkg::cmd_t                      cmd,
  input  mth_pkg::in_word_t                  in_word,
  input  logic                               cfg_we,
  input  logic [mth_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mth_pkg::CFG_DATA_W-1:0]     cfg_data,
  output mth_pkg::out_word_t                 out_word
);

  logic signed [31:0] offset_right;
  logic signed [31:0] offset_up;
  logic signed [31:0] offset_look;
  logic [30:0]        half_height;

  mth_pkg::in_word_t  frame;
  logic [63:0]        prod;
  logic               prod_neg;
  logic [63:0]        acc;
  logic [63:0]        rad;
  logic [33:0]        srem;
  logic [31:0]        root;
  logic [31:0]        drem;
  logic [16:0]        nlo;
  logic [16:0]        quo;
  logic [16:0]        nmag [3][3];
  logic               nsign [3][3];
  logic signed [35:0] acc_c;
  logic signed [31:0] cur_top [3];
  logic signed [31:0] cur_bot [3];
  logic               primed;
  mth_pkg::point_t    top_hist [mth_pkg::DEPTH];
  mth_pkg::point_t    bot_hist [mth_pkg::DEPTH];

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) return 32'sh7FFFFFFF;
    else if (v < -36'sh080000000) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // component select for the squared sum
  logic signed [31:0] sel_comp;
  always_comb begin
    case ({cmd.ax, cmd.comp})
      4'b0000: sel_comp = frame.right_x;
      4'b0001: sel_comp = frame.right_y;
      4'b0010: sel_comp = frame.right_z;
      4'b0100: sel_comp = frame.up_x;
      4'b0101: sel_comp = frame.up_y;
      4'b0110: sel_comp = frame.up_z;
      4'b1000: sel_comp = frame.look_x;
      4'b1001: sel_comp = frame.look_y;
      4'b1010: sel_comp = frame.look_z;
      default: sel_comp = '0;
    endcase
  end

  logic signed [31:0] sel_pos;
  always_comb begin
    case (cmd.comp)
      2'd0:    sel_pos = frame.pos_x;
      2'd1:    sel_pos = frame.pos_y;
      default: sel_pos = frame.pos_z;
    endcase
  end

  // operand for the normalized products, half height uses the up axis
  logic [1:0]  n_ax;
  logic [31:0] k_mag;
  logic        k_neg;
  always_comb begin
    n_ax = (cmd.ax == mth_pkg::AX_HALF) ? 2'd1 : cmd.ax;
    case (cmd.ax)
      2'd0:    begin k_mag = mag32(offset_right); k_neg = offset_right[31]; end
      2'd1:    begin k_mag = mag32(offset_up);    k_neg = offset_up[31];    end
      2'd2:    begin k_mag = mag32(offset_look);  k_neg = offset_look[31];  end
      default: begin k_mag = {1'b0, half_height}; k_neg = 1'b0;             end
    endcase
  end

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  always_comb begin
    if (cmd.op == mth_pkg::OP_SQ) begin
      mul_a = mag32(sel_comp);
      mul_b = mag32(sel_comp);
    end else begin
      mul_a = {15'd0, nmag[n_ax][cmd.comp]};
      mul_b = k_mag;
    end
  end

  // rounded q16.16 product term, half away from zero
  logic [48:0]        rnd_sum;
  logic [32:0]        rnd_mag;
  logic signed [35:0] term;
  assign rnd_sum = prod[48:0] + 49'd32768;
  assign rnd_mag = rnd_sum[48:16];
  assign term    = prod_neg ? -$signed({3'd0, rnd_mag}) : $signed({3'd0, rnd_mag});

  // square root step, two radicand bits a step
  logic [35:0] s_t;
  logic [35:0] s_trial;
  logic        s_ge;
  assign s_t     = {srem, rad[63:62]};
  assign s_trial = {2'd0, root, 2'b01};
  assign s_ge    = (s_t >= s_trial);

  // divider step, one quotient bit a step
  logic [32:0] d_t;
  logic        d_ge;
  logic [16:0] quo_next;
  assign d_t      = {drem, nlo[16]};
  assign d_ge     = (d_t >= {1'b0, root});
  assign quo_next = {quo[15:0], d_ge};

  logic [48:0] num;
  assign num = {mag32(sel_comp), 16'd0} + {18'd0, root[31:1]};

  logic signed [31:0] c_sat;
  assign c_sat = sat32(acc_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_right <= '0;
      offset_up    <= '0;
      offset_look  <= '0;
      half_height  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mth_pkg::REG_OFFSET_RIGHT: offset_right <= cfg_data;
        mth_pkg::REG_OFFSET_UP:    offset_up    <= cfg_data;
        mth_pkg::REG_OFFSET_LOOK:  offset_look  <= cfg_data;
        mth_pkg::REG_HALF_HEIGHT:  half_height  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) primed <= 1'b0;
    else if (cmd.op == mth_pkg::OP_PUSH) primed <= 1'b1;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mth_pkg::OP_LOAD: frame <= in_word;
      mth_pkg::OP_SQ: prod <= mul_a * mul_b;
      mth_pkg::OP_MULN: begin
        prod     <= mul_a * mul_b;
        prod_neg <= nsign[n_ax][cmd.comp] ^ k_neg;
      end
      mth_pkg::OP_ACC: acc <= (cmd.comp == 2'd0) ? prod : acc + prod;
      mth_pkg::OP_SQRT_INIT: begin
        rad  <= acc;
        srem <= '0;
        root <= '0;
      end
      mth_pkg::OP_SQRT: begin
        rad  <= {rad[61:0], 2'b00};
        srem <= s_ge ? 34'(s_t - s_trial) : s_t[33:0];
        root <= {root[30:0], s_ge};
      end
      mth_pkg::OP_DIV_INIT: begin
        drem <= num[48:17];
        nlo  <= num[16:0];
        quo  <= '0;
      end
      mth_pkg::OP_DIV: begin
        drem <= d_ge ? 32'(d_t - {1'b0, root}) : d_t[31:0];
        nlo  <= {nlo[15:0], 1'b0};
        quo  <= quo_next;
        if (cmd.last_step) begin
          // zero length axis normalizes to zero
          nmag[cmd.ax][cmd.comp]  <= (root == '0) ? '0 : quo_next;
          nsign[cmd.ax][cmd.comp] <= sel_comp[31];
        end
      end
      mth_pkg::OP_CINIT: acc_c <= 36'(sel_pos);
      mth_pkg::OP_ADD: acc_c <= acc_c + term;
      mth_pkg::OP_SAT: begin
        cur_top[cmd.comp] <= sat32(36'(c_sat) + term);
        cur_bot[cmd.comp] <= sat32(36'(c_sat) - term);
      end
      mth_pkg::OP_PUSH: begin
        for (int i = 0; i < mth_pkg::DEPTH; i++) begin
          if (!primed || i == 0) begin
            top_hist[i] <= '{cur_top[0], cur_top[1], cur_top[2]};
            bot_hist[i] <= '{cur_bot[0], cur_bot[1], cur_bot[2]};
          end else begin
            top_hist[i] <= top_hist[i-1];
            bot_hist[i] <= bot_hist[i-1];
          end
        end
      end
      mth_pkg::OP_EMIT: begin
        out_word.point_index <= cmd.idx;
        out_word.top_x       <= top_hist[0].x;
        out_word.top_y       <= top_hist[0].y;
        out_word.top_z       <= top_hist[0].z;
        out_word.bottom_x    <= bot_hist[0].x;
        out_word.bottom_y    <= bot_hist[0].y;
        out_word.bottom_z    <= bot_hist[0].z;
        out_word.last_point  <= cmd.last;
      end
      mth_pkg::OP_ROTATE: begin
        // each rotate moves the line by one entry; a full turn brings it back to its order
        for (int i = 0; i < mth_pkg::DEPTH; i++) begin
          if (i == mth_pkg::DEPTH - 1) begin
            top_hist[i] <= top_hist[0];
            bot_hist[i] <= bot_hist[0];
          end else begin
            top_hist[i] <= top_hist[i+1];
            bot_hist[i] <= bot_hist[i+1];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/motion_trail_history_tb.sv -----
// testbench for motion_trail_history: directed frames, then random frames under several
// register settings, every emitted point pair checked against a built-in predictor
// depends on mth_pkg and the motion_trail_history rtl
`timescale 1ns / 1ps

module motion_trail_history_tb;

  localparam logic [mth_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_FRAMES = 340;
  localparam int PHASES = 5;

  typedef struct {
    mth_pkg::in_word_t w;
    bit                typed;
    mth_pkg::point_t   pt;
  } frame_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  mth_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_ready;
  mth_pkg::out_word_t out_word;
  logic               cfg_we;
  logic [mth_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mth_pkg::CFG_DATA_W-1:0] cfg_data;

  motion_trail_history u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and trail
  longint             off_right, off_up, off_look, half_h;
  mth_pkg::point_t    trail_top [mth_pkg::DEPTH];
  mth_pkg::point_t    trail_bot [mth_pkg::DEPTH];
  bit                 primed;
  mth_pkg::out_word_t pair_q [$];
  int                 mismatch_count;
  bit                 calm;
  bit                 typed_pending;
  mth_pkg::point_t    typed_pt;
  int                 out_count;
  int                 seen_count;
  int                 out_stall;
  frame_row_t         rows [12];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void unit_axis(input longint a, b, c, output longint na, nb, nc);
    longint unsigned s, len;
    s = mag(a) * mag(a) + mag(b) * mag(b) + mag(c) * mag(c);
    len = root64(s);
    if (len == 0) begin
      na = 0; nb = 0; nc = 0;
    end else begin
      na = longint'((mag(a) * 65536 + len / 2) / len);
      nb = longint'((mag(b) * 65536 + len / 2) / len);
      nc = longint'((mag(c) * 65536 + len / 2) / len);
      if (a < 0) na = -na;
      if (b < 0) nb = -nb;
      if (c < 0) nc = -nc;
    end
  endfunction

  // rounded q16.16 product, half away from zero
  function automatic longint scale(longint n, longint k);
    longint r;
    r = longint'((mag(n) * mag(k) + 32768) >> 16);
    return ((n < 0) != (k < 0)) ? -r : r;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void predict_trail(mth_pkg::in_word_t w);
    longint nr [3], nu [3], nl [3], ps [3], c, h;
    logic signed [31:0] tp [3], bt [3];
    mth_pkg::point_t nt, nbt;
    mth_pkg::out_word_t o;
    unit_axis(w.right_x, w.right_y, w.right_z, nr[0], nr[1], nr[2]);
    unit_axis(w.up_x, w.up_y, w.up_z, nu[0], nu[1], nu[2]);
    unit_axis(w.look_x, w.look_y, w.look_z, nl[0], nl[1], nl[2]);
    ps[0] = w.pos_x; ps[1] = w.pos_y; ps[2] = w.pos_z;
    for (int k = 0; k < 3; k++) begin
      c = ps[k] + scale(nr[k], off_right) + scale(nu[k], off_up)
          + scale(nl[k], off_look);
      h = scale(nu[k], half_h);
      c = clamp32(c);
      tp[k] = clamp32(c + h);
      bt[k] = clamp32(c - h);
    end
    nt = '{x: tp[0], y: tp[1], z: tp[2]};
    nbt = '{x: bt[0], y: bt[1], z: bt[2]};
    if (!primed) begin
      for (int i = 0; i < mth_pkg::DEPTH; i++) begin
        trail_top[i] = nt;
        trail_bot[i] = nbt;
      end
      primed = 1'b1;
    end else begin
      for (int i = mth_pkg::DEPTH - 1; i > 0; i--) begin
        trail_top[i] = trail_top[i-1];
        trail_bot[i] = trail_bot[i-1];
      end
      trail_top[0] = nt;
      trail_bot[0] = nbt;
    end
    for (int i = 0; i < mth_pkg::DEPTH; i++) begin
      o.point_index = i[mth_pkg::IDX_W-1:0];
      o.top_x = trail_top[i].x; o.top_y = trail_top[i].y; o.top_z = trail_top[i].z;
      o.bottom_x = trail_bot[i].x; o.bottom_y = trail_bot[i].y;
      o.bottom_z = trail_bot[i].z;
      o.last_point = (i == mth_pkg::DEPTH - 1);
      pair_q.push_back(o);
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s at %0t: got %0d expected %0d", what, $realtime, got, want);
    mismatch_count++;
  endtask

  task automatic check_pair(mth_pkg::out_word_t g);
    mth_pkg::out_word_t e;
    if (pair_q.size() == 0) begin
      report_mismatch("unexpected word, index", g.point_index, -1);
      return;
    end
    e = pair_q.pop_front();
    if (g.point_index !== e.point_index)
      report_mismatch("point_index", g.point_index, e.point_index);
    if (g.top_x !== e.top_x) report_mismatch("top_x", g.top_x, e.top_x);
    if (g.top_y !== e.top_y) report_mismatch("top_y", g.top_y, e.top_y);
    if (g.top_z !== e.top_z) report_mismatch("top_z", g.top_z, e.top_z);
    if (g.bottom_x !== e.bottom_x) report_mismatch("bottom_x", g.bottom_x, e.bottom_x);
    if (g.bottom_y !== e.bottom_y) report_mismatch("bottom_y", g.bottom_y, e.bottom_y);
    if (g.bottom_z !== e.bottom_z) report_mismatch("bottom_z", g.bottom_z, e.bottom_z);
    if (g.last_point !== e.last_point)
      report_mismatch("last_point", g.last_point, e.last_point);
  endtask

  // inputs are sampled here before the edge updates anything
  always @(posedge clk) begin
    int base;
    if (!rst && in_valid && in_ready) begin
      predict_trail(in_word);
      if (typed_pending) begin
        base = pair_q.size() - mth_pkg::DEPTH;
        pair_q[base].top_x = typed_pt.x; pair_q[base].top_y = typed_pt.y;
        pair_q[base].top_z = typed_pt.z;
        pair_q[base].bottom_x = typed_pt.x; pair_q[base].bottom_y = typed_pt.y;
        pair_q[base].bottom_z = typed_pt.z;
        typed_pending = 1'b0;
      end
    end
    if (!rst && out_valid && out_ready) begin
      check_pair(out_word);
      out_count++;
    end
  end

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // sink stall drawn anew for every word taken
  always @(negedge clk) begin
    if (out_count != seen_count) begin
      seen_count = out_count;
      out_stall = idle_draw();
    end
    out_ready <= (out_stall == 0);
    if (out_stall > 0) out_stall--;
  end

  task automatic send_frame(mth_pkg::in_word_t w);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [mth_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mth_pkg::REG_OFFSET_RIGHT: off_right = longint'(signed'(val));
      mth_pkg::REG_OFFSET_UP:    off_up = longint'(signed'(val));
      mth_pkg::REG_OFFSET_LOOK:  off_look = longint'(signed'(val));
      mth_pkg::REG_HALF_HEIGHT:  half_h = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (pair_q.size() == 0);
    @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_all(logic [31:0] r, u, l, hh);
    write_reg(mth_pkg::REG_OFFSET_RIGHT, r);
    write_reg(mth_pkg::REG_OFFSET_UP, u);
    write_reg(mth_pkg::REG_OFFSET_LOOK, l);
    write_reg(mth_pkg::REG_HALF_HEIGHT, hh);
  endtask

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic mth_pkg::in_word_t rand_frame();
    mth_pkg::in_word_t w;
    int ka, kb, kc, kp;
    ka = $urandom_range(0, 9) < 5 ? 1 :
         ($urandom_range(0, 9) < 8 ? 0 : $urandom_range(2, 3));
    kb = $urandom_range(0, 9) < 5 ? 1 :
         ($urandom_range(0, 9) < 8 ? 0 : $urandom_range(2, 3));
    kc = $urandom_range(0, 9) < 5 ? 1 :
         ($urandom_range(0, 9) < 8 ? 0 : $urandom_range(2, 3));
    kp = $urandom_range(0, 3) == 0 ? 0 : 1;
    w.right_x = rand_coord(ka); w.right_y = rand_coord(ka); w.right_z = rand_coord(ka);
    w.up_x = rand_coord(kb); w.up_y = rand_coord(kb); w.up_z = rand_coord(kb);
    w.look_x = rand_coord(kc); w.look_y = rand_coord(kc); w.look_z = rand_coord(kc);
    w.pos_x = rand_coord(kp); w.pos_y = rand_coord(kp); w.pos_z = rand_coord(kp);
    return w;
  endfunction

  task automatic build_rows();
    mth_pkg::in_word_t z;
    z = '0;
    foreach (rows[i]) rows[i] = '{w: z, typed: 1'b0, pt: '0};
    // zero axes leave the position untouched
    rows[0].typed = 1'b1;
    rows[1].w.pos_x = 32'sh7fffffff; rows[1].w.pos_y = 32'sh7fffffff;
    rows[1].w.pos_z = 32'sh7fffffff;
    rows[1].typed = 1'b1;
    rows[1].pt = '{x: 32'sh7fffffff, y: 32'sh7fffffff, z: 32'sh7fffffff};
    rows[2].w.pos_x = 32'sh80000000; rows[2].w.pos_y = 32'sh80000000;
    rows[2].w.pos_z = 32'sh80000000;
    rows[2].typed = 1'b1;
    rows[2].pt = '{x: 32'sh80000000, y: 32'sh80000000, z: 32'sh80000000};
    rows[3].w.right_x = 32'sh10000; rows[3].w.up_y = 32'sh10000;
    rows[3].w.look_z = 32'sh10000;
    rows[3].w.pos_x = 32'sh1; rows[3].w.pos_y = -32'sh1; rows[3].w.pos_z = 32'sh12345678;
    rows[3].typed = 1'b1;
    rows[3].pt = '{x: 32'sh1, y: -32'sh1, z: 32'sh12345678};
    rows[4].w = '1;
    rows[5].w.right_x = 32'sh80000000; rows[5].w.up_x = 32'sh7fffffff;
    rows[5].w.up_y = 32'sh7fffffff; rows[5].w.up_z = 32'sh7fffffff;
    rows[5].w.look_x = 32'sh80000000; rows[5].w.look_y = 32'sh80000000;
    rows[5].w.look_z = 32'sh80000000; rows[5].w.pos_x = 32'sh7fff0000;
    rows[6].w.up_x = -32'sh10000; rows[6].w.right_y = 32'sh3; rows[6].w.look_z = -32'sh1;
    rows[6].w.pos_y = 32'sh80000000;
    rows[7].w.right_x = 32'sh3; rows[7].w.right_y = 32'sh4;
    rows[7].w.up_y = -32'sh5; rows[7].w.up_z = 32'sh12;
    rows[7].w.look_x = 32'sh7fffffff; rows[7].w.pos_z = 32'sh7fffffff;
    rows[8].w.up_z = 32'sh1; rows[8].w.right_z = 32'sh80000000;
    rows[8].w.pos_x = 32'sh55555555;
    rows[9].w.up_x = 32'sh80000000; rows[9].w.up_y = 32'sh80000000;
    rows[9].w.pos_z = 32'shaaaaaaaa;
    rows[10].w.right_x = 32'sh7fffffff; rows[10].w.up_y = 32'sh1;
    rows[10].w.look_y = 32'sh7fffffff; rows[10].w.pos_y = 32'sh7fffffff;
    rows[11].w.look_x = -32'sh10000; rows[11].w.up_z = 32'sh80000000;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    off_right = 0; off_up = 0; off_look = 0; half_h = 0;
    primed = 1'b0;
    mismatch_count = 0;
    calm = 1'b0;
    typed_pending = 1'b0;
    out_count = 0;
    seen_count = 0;
    out_stall = 0;
    foreach (trail_top[i]) begin
      trail_top[i] = '0;
      trail_bot[i] = '0;
    end
    build_rows();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers at reset value: rows with typed results apply
    foreach (rows[i]) begin
      typed_pt = rows[i].pt;
      typed_pending = rows[i].typed;
      send_frame(rows[i].w);
    end
    settle();
    // saturating extremes
    write_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    foreach (rows[i]) send_frame(rows[i].w);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      calm = (ph == 2);
      case (ph)
        0: write_all($urandom(), $urandom(), $urandom(), $urandom());
        1: write_all($urandom_range(0, 32'h40000), -$urandom_range(0, 32'h40000),
                     $urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000));
        2: write_all(32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff);
        3: write_all(32'h0, 32'h0, 32'h0, 32'h0);
        default: begin
          write_all($urandom(), $urandom(), $urandom(), 32'h80000000 | $urandom());
          write_reg(REG_UNUSED, $urandom());
        end
      endcase
      repeat (RANDOM_FRAMES / PHASES) send_frame(rand_frame());
    end

    in_valid <= 1'b0;
    wait (pair_q.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
